// ----- hdl/efr_pkg.sv -----
// Shared constants for the escaped frame receiver: flag codes, size limits
// and the 8-bit Pearson permutation table used by the frame check.
// No dependencies.
package efr_pkg;

  localparam int MAX_DATA  = 50;
  localparam int FRAME_MAX = 128;

  localparam int BYTE_W  = 8;
  localparam int CNT_W   = $clog2(FRAME_MAX + 1);
  localparam int ADDR_W  = $clog2(MAX_DATA);
  localparam int INDEX_W = 6;

  localparam logic [BYTE_W-1:0] START_FLAG  = 8'hFF;
  localparam logic [BYTE_W-1:0] END_FLAG    = 8'hFE;
  localparam logic [BYTE_W-1:0] ESCAPE_MARK = 8'hFD;
  localparam logic [BYTE_W-1:0] ESCAPE_ADD  = 8'd2;

  localparam int HEADER_LEN = 3;
  localparam int FRAME_OVERHEAD = 4;

  localparam logic [BYTE_W-1:0] PEARSON_TABLE [256] = '{
    8'h00,8'h77,8'hee,8'h99,8'h07,8'h70,8'he9,8'h9e,
    8'h0e,8'h79,8'he0,8'h97,8'h09,8'h7e,8'he7,8'h90,
    8'h1d,8'h6a,8'hf3,8'h84,8'h1a,8'h6d,8'hf4,8'h83,
    8'h13,8'h64,8'hfd,8'h8a,8'h14,8'h63,8'hfa,8'h8d,
    8'h3b,8'h4c,8'hd5,8'ha2,8'h3c,8'h4b,8'hd2,8'ha5,
    8'h35,8'h42,8'hdb,8'hac,8'h32,8'h45,8'hdc,8'hab,
    8'h26,8'h51,8'hc8,8'hbf,8'h21,8'h56,8'hcf,8'hb8,
    8'h28,8'h5f,8'hc6,8'hb1,8'h2f,8'h58,8'hc1,8'hb6,
    8'h76,8'h01,8'h98,8'hef,8'h71,8'h06,8'h9f,8'he8,
    8'h78,8'h0f,8'h96,8'he1,8'h7f,8'h08,8'h91,8'he6,
    8'h6b,8'h1c,8'h85,8'hf2,8'h6c,8'h1b,8'h82,8'hf5,
    8'h65,8'h12,8'h8b,8'hfc,8'h62,8'h15,8'h8c,8'hfb,
    8'h4d,8'h3a,8'ha3,8'hd4,8'h4a,8'h3d,8'ha4,8'hd3,
    8'h43,8'h34,8'had,8'hda,8'h44,8'h33,8'haa,8'hdd,
    8'h50,8'h27,8'hbe,8'hc9,8'h57,8'h20,8'hb9,8'hce,
    8'h5e,8'h29,8'hb0,8'hc7,8'h59,8'h2e,8'hb7,8'hc0,
    8'hed,8'h9a,8'h03,8'h74,8'hea,8'h9d,8'h04,8'h73,
    8'he3,8'h94,8'h0d,8'h7a,8'he4,8'h93,8'h0a,8'h7d,
    8'hf0,8'h87,8'h1e,8'h69,8'hf7,8'h80,8'h19,8'h6e,
    8'hfe,8'h89,8'h10,8'h67,8'hf9,8'h8e,8'h17,8'h60,
    8'hd6,8'ha1,8'h38,8'h4f,8'hd1,8'ha6,8'h3f,8'h48,
    8'hd8,8'haf,8'h36,8'h41,8'hdf,8'ha8,8'h31,8'h46,
    8'hcb,8'hbc,8'h25,8'h52,8'hcc,8'hbb,8'h22,8'h55,
    8'hc5,8'hb2,8'h2b,8'h5c,8'hc2,8'hb5,8'h2c,8'h5b,
    8'h9b,8'hec,8'h75,8'h02,8'h9c,8'heb,8'h72,8'h05,
    8'h95,8'he2,8'h7b,8'h0c,8'h92,8'he5,8'h7c,8'h0b,
    8'h86,8'hf1,8'h68,8'h1f,8'h81,8'hf6,8'h6f,8'h18,
    8'h88,8'hff,8'h66,8'h11,8'h8f,8'hf8,8'h61,8'h16,
    8'ha0,8'hd7,8'h4e,8'h39,8'ha7,8'hd0,8'h49,8'h3e,
    8'hae,8'hd9,8'h40,8'h37,8'ha9,8'hde,8'h47,8'h30,
    8'hbd,8'hca,8'h53,8'h24,8'hba,8'hcd,8'h54,8'h23,
    8'hb3,8'hc4,8'h5d,8'h2a,8'hb4,8'hc3,8'h5a,8'h2d
  };

endpackage

// ----- hdl/efr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Contents are undefined until written. No dependencies.
module efr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 50,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/escaped_frame_receiver_pearson.sv -----
// Top level of the byte-stuffed frame receiver with an 8-bit Pearson check.
// Uses efr_pkg and one efr_ram instance for the payload bytes.
//
// The block takes one received byte per cycle while a frame is coming in; only
// an end flag waits while the output register still holds a result that is not
// taken. A start flag opens a frame, an escape mark adds two to the next byte,
// and an end flag checks the frame. A rejected frame, or a good frame without
// data, gives one result at once. A good frame with n data bytes gives n
// results, each via S_READ then S_LOAD, since every payload byte is read from
// the payload RAM before it is loaded into the output register; input bytes
// are stalled for that readout plus any output stall. No clearing pass is run.
module escaped_frame_receiver_pearson
  import efr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [BYTE_W-1:0]  rx_byte,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               frame_ok,
  output logic [BYTE_W-1:0]  command,
  output logic               has_data,
  output logic [BYTE_W-1:0]  data_byte,
  output logic [INDEX_W-1:0] data_index,
  output logic               last
);

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]  stored_count;
  logic [BYTE_W-1:0] first_stored;
  logic [BYTE_W-1:0] command_byte;
  logic [BYTE_W-1:0] length_field;
  logic [BYTE_W-1:0] running_hash;
  logic [BYTE_W-1:0] held_byte;
  logic              escape_pending;
  logic [ADDR_W-1:0] rd_idx;

  logic              out_free;
  logic              rx_take;
  logic              is_start;
  logic              is_end;
  logic              is_data;
  logic              do_store;
  logic              overflow;
  logic [BYTE_W-1:0] store_val;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  pay_pos;
  logic              pay_write;
  logic              frame_good;
  logic              rd_last;
  logic [BYTE_W-1:0] ram_rdata;

  assign out_free = !res_valid || !res_stall;
  assign is_start = rx_byte == START_FLAG;
  assign is_end   = rx_byte == END_FLAG;
  assign rx_stall = (state != S_RUN) || (is_end && !out_free);
  assign rx_take  = rx_valid && !rx_stall;

  assign is_data   = !is_start && !is_end && (escape_pending || rx_byte != ESCAPE_MARK);
  assign store_val = (escape_pending && is_data) ? rx_byte + ESCAPE_ADD : rx_byte;
  assign overflow  = is_data && stored_count >= CNT_W'(FRAME_MAX);
  assign do_store  = is_start || (is_data && !overflow);
  assign pos       = is_start ? '0 : stored_count;
  assign pay_pos   = pos - CNT_W'(HEADER_LEN);
  assign pay_write = rx_take && do_store && pos >= CNT_W'(HEADER_LEN)
                     && pay_pos < CNT_W'(MAX_DATA);

  assign frame_good = stored_count >= CNT_W'(FRAME_OVERHEAD)
                      && first_stored == START_FLAG
                      && running_hash == held_byte
                      && CNT_W'(length_field) == stored_count - CNT_W'(FRAME_OVERHEAD)
                      && length_field <= BYTE_W'(MAX_DATA);

  assign rd_last = rd_idx == ADDR_W'(length_field - BYTE_W'(1));

  efr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_DATA)
  ) u_payload (
    .clk  (clk),
    .we   (pay_write),
    .waddr(pay_pos[ADDR_W-1:0]),
    .wdata(store_val),
    .re   (state == S_READ),
    .raddr(rd_idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (rx_take && is_end && frame_good && length_field != '0) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          state_next = rd_last ? S_RUN : S_READ;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_RUN;
      stored_count   <= '0;
      first_stored   <= '0;
      command_byte   <= '0;
      length_field   <= '0;
      running_hash   <= '0;
      held_byte      <= '0;
      escape_pending <= 1'b0;
      rd_idx         <= '0;
      res_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (rx_take && is_end && (!frame_good || length_field == '0)) begin
        res_valid <= 1'b1;
      end else if (state == S_LOAD && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (rx_take) begin
        if (is_data) begin
          escape_pending <= escape_pending ? 1'b0 : escape_pending;
        end
        if (!is_start && !is_end && !escape_pending && rx_byte == ESCAPE_MARK) begin
          escape_pending <= 1'b1;
        end
        if (is_end || overflow) begin
          stored_count <= '0;
        end
        if (do_store) begin
          if (pos >= CNT_W'(2)) begin
            running_hash <= PEARSON_TABLE[running_hash ^ held_byte];
          end
          if (pos == '0) begin
            first_stored <= store_val;
            running_hash <= '0;
          end
          if (pos == CNT_W'(1)) begin
            command_byte <= store_val;
          end
          if (pos == CNT_W'(2)) begin
            length_field <= store_val;
          end
          held_byte    <= store_val;
          stored_count <= pos + CNT_W'(1);
        end
        if (is_end) begin
          rd_idx <= '0;
        end
      end
      if (state == S_LOAD && out_free) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take && is_end) begin
      frame_ok   <= frame_good;
      command    <= frame_good ? command_byte : '0;
      has_data   <= 1'b0;
      data_byte  <= '0;
      data_index <= '0;
      last       <= 1'b1;
    end else if (state == S_LOAD && out_free) begin
      frame_ok   <= 1'b1;
      command    <= command_byte;
      has_data   <= 1'b1;
      data_byte  <= ram_rdata;
      data_index <= INDEX_W'(rd_idx);
      last       <= rd_last;
    end
  end

endmodule
